// File: rtl/evest_pkg.sv
// ----------------------------------------------------------------------------
// evest_pkg
// Shared types, constants and register indexes for the encoder velocity
// estimator: word types, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package evest_pkg;

   // Default sizing
   localparam int COUNT_BITS_DEF    = 16;
   localparam int POSITION_BITS_DEF = 32;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int RATE_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOLUTION  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd2;

   localparam logic [RATE_W-1:0]     SAMPLE_RATE_RST = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] RESOLUTION_RST  = 31'd65536;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RST   = 31'd66;

   // Input word
   typedef struct packed {
      logic signed [31:0] position_sample;
      logic               restart;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] velocity_estimate;
      logic               moved;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// File: rtl/evest_ctrl.sv
// ----------------------------------------------------------------------------
// evest_ctrl
// Sequencer: takes a word, does the rate multiply, steps the divider, then
// waits for the output register before going back to idle.
// ----------------------------------------------------------------------------
module evest_ctrl #(
   parameter int DIV_STEPS = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  evest_pkg::stat_type stat,
   output evest_pkg::cmd_type  cmd
);

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   evest_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= evest_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         evest_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = evest_pkg::ST_MUL;
            end
         end
         evest_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = evest_pkg::ST_DIV;
         end
         evest_pkg::ST_DIV: begin
            cmd.div = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = evest_pkg::ST_DONE;
            end
         end
         evest_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = evest_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evest_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // Divider does not leave before its last step, ahead of the result stage
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == evest_pkg::ST_DIV && step_ff != LAST_STEP)
         |=> state_ff == evest_pkg::ST_DIV)
      else $error("divider left early");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == evest_pkg::ST_DIV |-> step_ff <= LAST_STEP)
      else $error("step counter out of range");
`endif

endmodule

// File: rtl/evest_dp.sv
// ----------------------------------------------------------------------------
// evest_dp
// Datapath: configuration registers, estimator state, delta and deadband
// check, rate multiply, radix-4 restoring divider, saturation and clamp,
// and the result register.
// ----------------------------------------------------------------------------
module evest_dp #(
   parameter int COUNT_BITS    = evest_pkg::COUNT_BITS_DEF,
   parameter int POSITION_BITS = evest_pkg::POSITION_BITS_DEF,
   parameter int OP_W          = 33,
   parameter int PW            = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [evest_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [evest_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  evest_pkg::req_type                  req_data,
   input  evest_pkg::cmd_type                  cmd,
   output evest_pkg::stat_type                 stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output evest_pkg::rsp_type                  rsp_data
);

   localparam int PB    = POSITION_BITS;
   localparam int CB    = COUNT_BITS;
   localparam int MAG_W = PB + 1;
   localparam int PW0   = OP_W + evest_pkg::RATE_W;
   localparam logic [63:0] SAT_LIM = 64'h1_0000_0000;

   // Configuration
   logic [evest_pkg::RATE_W-1:0]     rate_ff;
   logic [evest_pkg::CSR_DATA_W-1:0] res_ff;
   logic [evest_pkg::CSR_DATA_W-1:0] thr_ff;

   // Estimator state
   logic                 started_ff;
   logic signed [PB-1:0] ref_ff;
   logic [31:0]          held_ff;
   logic [CB-1:0]        cnt_ff;

   // Per-word working registers
   logic [CB-1:0]   div_ff;
   logic [OP_W-1:0] op_ff;
   logic            neg_ff;
   logic            moved_ff;
   logic            big_ff;
   logic [PW-1:0]   dvd_ff, dvd_in;
   logic [CB-1:0]   rem_ff, rem_in;

   evest_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;

   // Load-stage signals
   logic signed [PB-1:0] pos;
   logic                 fresh;
   logic signed [PB-1:0] ref_base;
   logic [MAG_W-1:0]     delta;
   logic [MAG_W-1:0]     mag;
   logic                 moved;
   logic [CB-1:0]        cnt_base;
   logic [CB-1:0]        cnt_inc;
   logic [PW0-1:0]       prod;
   logic                 big;

   // Result-stage signals
   logic [32:0] res33;
   logic [31:0] vel_moved;
   logic [30:0] bound;
   logic        hneg;
   logic [31:0] hmag;
   logic [31:0] vel_held;
   logic [31:0] held_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= evest_pkg::SAMPLE_RATE_RST;
         res_ff  <= evest_pkg::RESOLUTION_RST;
         thr_ff  <= evest_pkg::THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            evest_pkg::CSR_SAMPLE_RATE: rate_ff <= csr_wdata[evest_pkg::RATE_W-1:0];
            evest_pkg::CSR_RESOLUTION:  res_ff  <= csr_wdata;
            evest_pkg::CSR_THRESHOLD:   thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Delta against the reference and deadband test
   always_comb begin
      pos      = PB'(req_data.position_sample);
      fresh    = req_data.restart || !started_ff;
      ref_base = fresh ? pos : ref_ff;
      delta    = {pos[PB-1], pos} - {ref_base[PB-1], ref_base};
      mag      = delta[PB] ? (~delta + 1'b1) : delta;
      moved    = ({{31{1'b0}}, mag} > {{MAG_W{1'b0}}, thr_ff});
      cnt_base = fresh ? '0 : cnt_ff;
      cnt_inc  = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
   end

   // Rate multiply and quotient overflow check
   always_comb begin
      prod = PW0'(op_ff) * PW0'(rate_ff);
      big  = (({{CB{1'b0}}, op_ff} >> 32) >= {{OP_W{1'b0}}, div_ff});
   end

   // Two restoring division steps per cycle
   always_comb begin
      logic [CB:0]   t;
      logic [CB-1:0] r;
      logic [PW-1:0] x;
      r = rem_ff;
      x = dvd_ff;
      for (int i = 0; i < 2; i++) begin
         t = {r, x[PW-1]};
         x = {x[PW-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            t    = t - {1'b0, div_ff};
            x[0] = 1'b1;
         end
         r = t[CB-1:0];
      end
      rem_in = r;
      dvd_in = x;
   end

   // Saturate the quotient, then new velocity or clamped held velocity
   always_comb begin
      if (big_ff || (dvd_ff > PW'(SAT_LIM))) begin
         res33 = 33'h1_0000_0000;
      end else begin
         res33 = dvd_ff[32:0];
      end
      if (neg_ff) begin
         vel_moved = (res33 >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - res33[31:0]);
      end else begin
         vel_moved = (res33 > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : res33[31:0];
      end
      bound = (res33 > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : res33[30:0];
      hneg  = held_ff[31];
      hmag  = hneg ? (32'd0 - held_ff) : held_ff;
      if (hmag > {1'b0, bound}) begin
         vel_held = hneg ? (32'd0 - {1'b0, bound}) : {1'b0, bound};
      end else begin
         vel_held = held_ff;
      end
      held_in = moved_ff ? vel_moved : vel_held;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         held_ff      <= '0;
         cnt_ff       <= '0;
         ref_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            started_ff <= 1'b1;
            ref_ff     <= moved ? pos : ref_base;
            cnt_ff     <= moved ? '0 : cnt_inc;
            if (fresh) begin
               held_ff <= '0;
            end
         end
         if (cmd.finish) begin
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_ff   <= cnt_inc;
         op_ff    <= moved ? OP_W'(mag) : OP_W'(res_ff);
         neg_ff   <= delta[PB];
         moved_ff <= moved;
      end
      if (cmd.mul) begin
         dvd_ff <= PW'(prod);
         rem_ff <= '0;
         big_ff <= big;
      end else if (cmd.div) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         rsp_ff.velocity_estimate <= held_in;
         rsp_ff.moved             <= moved_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

`ifndef NO_ASSERTIONS
   // Count is at least one wherever it divides
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> div_ff != '0)
      else $error("divide by zero count");
   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> rem_ff < div_ff)
      else $error("remainder out of range");
   // A passed deadband leaves the sample count cleared
   a_move_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && moved_ff) |-> cnt_ff == '0)
      else $error("count not cleared after move");
`endif

endmodule

// File: rtl/encoder_velocity_estimator.sv
// ----------------------------------------------------------------------------
// encoder_velocity_estimator
// Each word passes the rate multiply, then the radix-4 serial divider, then
// the result register that drives rsp_valid. A new word is accepted only once
// the previous one has entered the result register, which waits while
// rsp_ready holds an earlier result there.
// Reset is synchronous: config returns to defaults, estimator unstarted.
// ----------------------------------------------------------------------------
module encoder_velocity_estimator #(
   parameter int COUNT_BITS    = evest_pkg::COUNT_BITS_DEF,
   parameter int POSITION_BITS = evest_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [evest_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [evest_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  evest_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output evest_pkg::rsp_type                rsp_data
);

   localparam int MAG_W     = POSITION_BITS + 1;
   localparam int OP_W      = (MAG_W > evest_pkg::CSR_DATA_W) ? MAG_W : evest_pkg::CSR_DATA_W;
   localparam int PW0       = OP_W + evest_pkg::RATE_W;
   localparam int PW        = PW0 + (PW0 % 2);
   localparam int DIV_STEPS = PW / 2;

   evest_pkg::cmd_type  cmd;
   evest_pkg::stat_type stat;

   evest_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   evest_dp #(
      .COUNT_BITS    (COUNT_BITS),
      .POSITION_BITS (POSITION_BITS),
      .OP_W          (OP_W),
      .PW            (PW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the encoder velocity estimator. Position words go in
// with random gaps on the request side and random stalls on the result side.
// An estimator kept inside the bench predicts every velocity word, and each
// result field is compared against it, over several register settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [evest_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          MAX_GAP       = 16;
   localparam int          TRACK_PHASES  = 6;
   localparam int          TRACK_WORDS   = 190;
   localparam logic [31:0] POS_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MIN       = 32'h8000_0000;
   localparam longint unsigned QUOT_SAT  = 64'h1_0000_0000;
   localparam longint unsigned VEL_MAX   = 64'h7FFF_FFFF;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              csr_we    = 1'b0;
   logic [evest_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [evest_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   evest_pkg::req_type                req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   evest_pkg::rsp_type                rsp_data;

   // Bench copy of the registers and the estimator state
   logic [evest_pkg::RATE_W-1:0]     rate_reg  = evest_pkg::SAMPLE_RATE_RST;
   logic [evest_pkg::CSR_DATA_W-1:0] res_reg   = evest_pkg::RESOLUTION_RST;
   logic [evest_pkg::CSR_DATA_W-1:0] thr_reg   = evest_pkg::THRESHOLD_RST;
   logic signed [31:0]    est_ref     = '0;
   logic [31:0]           est_held    = '0;
   logic [15:0]           est_count   = '0;
   bit                    est_started = 1'b0;

   evest_pkg::rsp_type velocity_expected[$];

   int  fail_count    = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  moved_count   = 0;
   int  setting_count = 1;
   bit  quiet_stretch = 1'b0;

   encoder_velocity_estimator DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // floor(mag * rate / cnt), clipped just above the 32-bit range
   function automatic longint unsigned rate_quotient(longint unsigned mag,
                                                     longint unsigned rate,
                                                     longint unsigned cnt);
      longint unsigned q, r, v;
      q = mag / cnt;
      r = mag % cnt;
      if (q >= QUOT_SAT) return QUOT_SAT;
      v = q * rate + (r * rate) / cnt;
      if (v > QUOT_SAT) v = QUOT_SAT;
      return v;
   endfunction

   // sign and magnitude to a saturated signed 32-bit velocity
   function automatic logic [31:0] sat_velocity(bit neg, longint unsigned mag);
      logic [63:0] t;
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'h8000_0000;
         t = 64'd0 - mag;
         return t[31:0];
      end
      if (mag > VEL_MAX) return VEL_MAX[31:0];
      return mag[31:0];
   endfunction

   // Advance the bench estimator by one word and queue the velocity it gives
   function automatic void predict_velocity(evest_pkg::req_type w);
      longint             delta;
      longint unsigned    mag, bound, hmag;
      logic [31:0]        neg_held;
      bit                 neg, hneg;
      evest_pkg::rsp_type r;
      if (w.restart || !est_started) begin
         est_ref     = w.position_sample;
         est_held    = '0;
         est_count   = '0;
         est_started = 1'b1;
      end
      if (est_count != 16'hFFFF) est_count++;
      delta = longint'($signed(w.position_sample)) - longint'(est_ref);
      neg   = delta < 0;
      mag   = neg ? longint'(-delta) : longint'(delta);
      r.moved = mag > longint'(thr_reg);
      if (r.moved) begin
         est_ref   = w.position_sample;
         est_held  = sat_velocity(neg, rate_quotient(mag, 64'(rate_reg), 64'(est_count)));
         est_count = '0;
      end else begin
         bound    = rate_quotient(64'(res_reg), 64'(rate_reg), 64'(est_count));
         hneg     = est_held[31];
         neg_held = 32'd0 - est_held;
         hmag     = hneg ? {32'd0, neg_held} : {32'd0, est_held};
         if (bound > VEL_MAX) bound = VEL_MAX;
         if (hmag > bound) est_held = sat_velocity(hneg, bound);
      end
      r.velocity_estimate = est_held;
      velocity_expected.push_back(r);
   endfunction

   function automatic int draw_gap();
      return quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Send one position word and wait for the handshake
   task automatic send_word(input logic [31:0] pos, input logic restart);
      evest_pkg::req_type w;
      int                 gap;
      w.position_sample = pos;
      w.restart         = restart;
      gap               = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predict_velocity(w);
      words_sent++;
   endtask

   // Hold off until every expected word is back and the block is quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (velocity_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [evest_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [evest_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         evest_pkg::CSR_SAMPLE_RATE: rate_reg = value[evest_pkg::RATE_W-1:0];
         evest_pkg::CSR_RESOLUTION:  res_reg  = value;
         evest_pkg::CSR_THRESHOLD:   thr_reg  = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [evest_pkg::CSR_DATA_W-1:0] rate,
                            input logic [evest_pkg::CSR_DATA_W-1:0] res,
                            input logic [evest_pkg::CSR_DATA_W-1:0] thr);
      wait_idle();
      csr_write(evest_pkg::CSR_SAMPLE_RATE, rate);
      csr_write(evest_pkg::CSR_RESOLUTION, res);
      csr_write(evest_pkg::CSR_THRESHOLD, thr);
      setting_count++;
   endtask

   // Defaults after reset: start-up, deadband edge, hold decay, full swings
   task automatic test_reset_defaults();
      send_word(32'h0001_0000, 1'b0);
      send_word(32'h0001_0042, 1'b0);   // exactly on the deadband
      send_word(32'h0001_0043, 1'b0);   // one past it
      repeat (3) send_word(32'h0001_0043, 1'b0);
      send_word(32'hFFB1_0043, 1'b0);   // backward move
      // most negative velocity, then its clamp while holding still
      send_word(POS_MAX, 1'b1);
      send_word(POS_MIN, 1'b0);
      send_word(POS_MIN, 1'b0);
      send_word(POS_MAX, 1'b0);
      send_word(POS_MAX, 1'b0);
      // restart drops the held velocity
      send_word(32'h0000_0000, 1'b1);
   endtask

   // Register extremes, zero rate, masking and the unused index
   task automatic test_register_extremes();
      // rate field wider than the register: upper bits dropped
      configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(POS_MIN, 1'b0);
      send_word(POS_MIN, 1'b0);
      // zero rate: every velocity and bound collapses to zero
      configure(31'd0, 31'd0, 31'h7FFF_FFFF);
      send_word(POS_MIN, 1'b0);
      send_word(POS_MAX, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      // a write to the spare index must not disturb anything
      wait_idle();
      csr_write(CSR_UNUSED, 31'h5555_5555);
      csr_write(evest_pkg::CSR_SAMPLE_RATE, 31'h7FFF_0001);
      csr_write(evest_pkg::CSR_RESOLUTION, 31'd1);
      setting_count++;
      send_word(32'h0000_0000, 1'b1);
      send_word(POS_MIN, 1'b0);
      send_word(POS_MIN, 1'b0);
   endtask

   function automatic logic [evest_pkg::CSR_DATA_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 31'd1;
         1: return 31'd65535;
         2: return 31'd1000;
         3: return 31'd0;
         default: return 31'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [evest_pkg::CSR_DATA_W-1:0] pick_span();
      case ($urandom_range(0, 4))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 255));
         3: return 31'($urandom_range(0, 1 << 20));
         default: return 31'($urandom >> 1);
      endcase
   endfunction

   // Encoder track: mostly holds and moves around the deadband, some big
   // jumps, wild samples and rail values
   function automatic logic [31:0] next_position(logic [31:0] p);
      logic [31:0] step;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         step = '0;
      else if (pick < 40)
         step = $urandom_range(0, thr_reg);
      else if (pick < 65)
         step = {1'b0, thr_reg} + $urandom_range(0, 2) - 1;
      else if (pick < 85)
         step = $urandom >> $urandom_range(0, 31);
      else if (pick < 95)
         return $urandom;
      else begin
         case ($urandom_range(0, 3))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if ($urandom_range(0, 1)) step = -step;
      return p + step;
   endfunction

   task automatic test_random_tracks();
      int          phase, n;
      logic [31:0] walk_pos;
      walk_pos = $urandom;
      for (phase = 0; phase < TRACK_PHASES; phase++) begin
         configure(pick_rate(), pick_span(), pick_span());
         for (n = 0; n < TRACK_WORDS; n++) begin
            if (n % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
            walk_pos = next_position(walk_pos);
            send_word(walk_pos, $urandom_range(0, 99) < 3);
         end
      end
      quiet_stretch = 1'b0;
   endtask

   // Result side: random stalls between words
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each returned word with the oldest prediction
   always @(posedge clock) begin
      evest_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (velocity_expected.size() == 0) begin
            $error("unexpected result word: velocity %h moved %b",
                   rsp_data.velocity_estimate, rsp_data.moved);
            fail_count++;
         end else begin
            want = velocity_expected.pop_front();
            words_checked++;
            if (want.moved) moved_count++;
            if (rsp_data.velocity_estimate !== want.velocity_estimate) begin
               $error("velocity_estimate: expected %h, got %h",
                      want.velocity_estimate, rsp_data.velocity_estimate);
               fail_count++;
            end
            if (rsp_data.moved !== want.moved) begin
               $error("moved: expected %b, got %b", want.moved, rsp_data.moved);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_tracks();
      wait_idle();
      $display("Sent %0d position words over %0d register settings;", words_sent,
               setting_count);
      $display("checked %0d velocity words, %0d of them past the deadband.",
               words_checked, moved_count);
      if (fail_count == 0)
         $display("encoder_velocity_estimator test passed");
      else
         $display("encoder_velocity_estimator test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("encoder_velocity_estimator test failed");
      $finish;
   end

endmodule
